/* rtl/cellular_automaton_row_engine_top_assert.svh */
// Assertion macros for the cellular automaton row engine RTL, included by ca_row_ctrl.
// Needs a clock named clock and an active-high reset named reset in scope.
// Leave SYNTH undefined in simulation to keep the checks.
`ifndef CELLULAR_AUTOMATON_ROW_ENGINE_TOP_ASSERT_SVH
`define CELLULAR_AUTOMATON_ROW_ENGINE_TOP_ASSERT_SVH

`ifndef SYNTH
// Condition must hold at every clock edge out of reset.
`define CAR_ASSERT_ALWAYS(lbl, expr) \
   lbl: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error("row engine check failed");
// Antecedent implies consequent in the next cycle.
`define CAR_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("row engine sequence check failed");
`else
`define CAR_ASSERT_ALWAYS(lbl, expr)
`define CAR_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

/* rtl/ca_row_pkg.sv */
// Shared constants, codes and controller/datapath structs for the row engine.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package ca_row_pkg;

   // Array geometry
   localparam int CELLS  = 32;
   localparam int ROWS   = 8;
   localparam int ROW_AW = $clog2(ROWS);
   localparam int NIB_W  = 4;
   localparam int NIB_N  = CELLS / NIB_W;
   localparam int NIB_CW = $clog2(NIB_N);
   localparam int CNT_W  = $clog2(ROWS * CELLS + 1);

   // Field widths
   localparam int ROW_FIELD_W = 32;
   localparam int CNT_FIELD_W = 9;
   localparam int RULE_W      = 8;
   localparam int THR_W       = 9;
   localparam int GEN_W       = 16;
   localparam int CMP_W       = (CNT_W > THR_W) ? CNT_W : THR_W;

   // Stream packing
   localparam int REQ_USED_W  = ROW_FIELD_W + 2;
   localparam int REQ_TDATA_W = ((REQ_USED_W + 7) / 8) * 8;
   localparam int RSP_USED_W  = ROW_FIELD_W + 2 * CNT_FIELD_W;
   localparam int RSP_TDATA_W = ((RSP_USED_W + 7) / 8) * 8;
   localparam int RSP_PAD_W   = RSP_TDATA_W - RSP_USED_W;

   // Configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_RULE      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HOLDOFF   = 2'd2;

   // Register reset values
   localparam logic [RULE_W-1:0] RULE_RESET      = 8'd30;
   localparam logic [THR_W-1:0]  THRESHOLD_RESET = 9'd6;
   localparam logic [GEN_W-1:0]  HOLDOFF_RESET   = 16'd8;

   // Request kinds
   localparam logic REQ_SEED = 1'b0;
   localparam logic REQ_STEP = 1'b1;

   // Controller to datapath
   typedef struct packed {
      logic              accept;
      logic              seed;
      logic              rd_scan;
      logic [ROW_AW-1:0] scan_addr;
      logic              scan_load;
      logic              scan_nib;
      logic              finish;
   } ca_row_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic rsp_free;
   } ca_row_status_type;

endpackage

`default_nettype wire

/* rtl/ca_row_dpath.sv */
// Datapath of the row engine: config registers, row store, next-row rule,
// nibble-serial population and zero-run scan, result register.
// Depends on ca_row_pkg; driven by ca_row_ctrl commands.
`timescale 1ns / 1ps
`default_nettype none

module ca_row_dpath (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire ca_row_pkg::ca_row_cmd_type            cmd,
   output ca_row_pkg::ca_row_status_type              status,
   input  wire logic [ca_row_pkg::ROW_FIELD_W-1:0]    seed_row,
   input  wire logic                                  left_in,
   input  wire logic                                  right_in,
   input  wire logic                                  csr_write,
   input  wire logic [ca_row_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [ca_row_pkg::CSR_DATA_W-1:0]     csr_data,
   output logic                                       rsp_tvalid,
   input  wire logic                                  rsp_tready,
   output logic [ca_row_pkg::ROW_FIELD_W-1:0]         row_out,
   output logic [ca_row_pkg::CNT_FIELD_W-1:0]         population,
   output logic [ca_row_pkg::CNT_FIELD_W-1:0]         max_zero_run,
   output logic                                       trigger
);
   import ca_row_pkg::*;

   // Configuration
   logic [RULE_W-1:0] rule_ff;
   logic [THR_W-1:0]  thr_ff;
   logic [GEN_W-1:0]  hold_ff;

   // Row store and its read port
   logic [CELLS-1:0]  mem [ROWS];
   logic [ROWS-1:0]   valid_ff, valid_in;
   logic [CELLS-1:0]  rd_data_ff;
   logic              rd_vld_ff;
   logic [CELLS-1:0]  rd_row;
   logic              mem_we;
   logic [ROW_AW-1:0] mem_wa;
   logic [CELLS-1:0]  mem_wd;

   // Generation state
   logic [CELLS-1:0]  cur_row_ff, cur_row_in;
   logic [ROW_AW-1:0] ptr_ff, ptr_in, ptr_next;
   logic [GEN_W-1:0]  gen_ff, gen_in, gen_next, gen_diff;
   logic [GEN_W-1:0]  last_ff, last_in;
   logic              check_ff, check_in;
   logic [CELLS-1:0]  new_row;

   // Scan accumulators
   logic [CELLS-1:0]  shift_ff, shift_in;
   logic [CNT_W-1:0]  pop_ff, pop_in;
   logic [CNT_W-1:0]  run_ff, run_in;
   logic [CNT_W-1:0]  best_ff, best_in;
   logic [NIB_W-1:0]  nib;
   logic [CNT_W-1:0]  nib_pop, nib_run, nib_best;
   logic              fire;

   // Result register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [CELLS-1:0]       rsp_row_ff;
   logic [CNT_W-1:0]       rsp_pop_ff, rsp_run_ff;
   logic                   rsp_trig_ff;

   // Configuration writes; unknown indexes drop
   always_ff @(posedge clock) begin
      if (reset) begin
         rule_ff <= RULE_RESET;
         thr_ff  <= THRESHOLD_RESET;
         hold_ff <= HOLDOFF_RESET;
      end else if (csr_write) begin
         case (csr_index)
            CSR_RULE:      rule_ff <= csr_data[RULE_W-1:0];
            CSR_THRESHOLD: thr_ff  <= csr_data[THR_W-1:0];
            CSR_HOLDOFF:   hold_ff <= csr_data[GEN_W-1:0];
            default:       ;
         endcase
      end
   end

   // Next row from the current row and the edge cells
   always_comb begin
      logic [2:0] idx;
      for (int b = 0; b < CELLS; b++) begin
         idx[2] = (b == CELLS - 1) ? left_in  : cur_row_ff[(b + 1) % CELLS];
         idx[1] = cur_row_ff[b];
         idx[0] = (b == 0)         ? right_in : cur_row_ff[(b + CELLS - 1) % CELLS];
         new_row[b] = rule_ff[idx];
      end
   end

   // Ring pointer and holdoff distance after one more generation
   assign ptr_next = (ptr_ff == ROW_AW'(ROWS - 1)) ? '0 : ptr_ff + ROW_AW'(1);
   assign gen_next = gen_ff + GEN_W'(1);
   assign gen_diff = gen_next - last_ff;

   // Trigger decision on the finished scan
   assign fire = check_ff && (CMP_W'(best_ff) > CMP_W'(thr_ff));

   // Seed or step on accept; record the trigger on finish
   always_comb begin
      valid_in   = valid_ff;
      cur_row_in = cur_row_ff;
      ptr_in     = ptr_ff;
      gen_in     = gen_ff;
      last_in    = last_ff;
      check_in   = check_ff;
      mem_we     = 1'b0;
      mem_wa     = '0;
      mem_wd     = '0;
      if (cmd.accept) begin
         mem_we = 1'b1;
         if (cmd.seed) begin
            valid_in    = '0;
            valid_in[0] = 1'b1;
            cur_row_in  = CELLS'(seed_row);
            ptr_in      = '0;
            gen_in      = '0;
            last_in     = '0;
            check_in    = 1'b0;
            mem_wa      = '0;
            mem_wd      = CELLS'(seed_row);
         end else begin
            valid_in[ptr_next] = 1'b1;
            cur_row_in = new_row;
            ptr_in     = ptr_next;
            gen_in     = gen_next;
            check_in   = gen_diff > hold_ff;
            mem_wa     = ptr_next;
            mem_wd     = new_row;
         end
      end
      if (cmd.finish && fire) begin
         last_in = gen_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= '0;
         cur_row_ff <= '0;
         ptr_ff     <= '0;
         gen_ff     <= '0;
         last_ff    <= '0;
         check_ff   <= 1'b0;
      end else begin
         valid_ff   <= valid_in;
         cur_row_ff <= cur_row_in;
         ptr_ff     <= ptr_in;
         gen_ff     <= gen_in;
         last_ff    <= last_in;
         check_ff   <= check_in;
      end
   end

   // Row store: one write, one registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      if (cmd.rd_scan) begin
         rd_data_ff <= mem[cmd.scan_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff <= 1'b0;
      end else if (cmd.rd_scan) begin
         rd_vld_ff <= valid_ff[cmd.scan_addr];
      end
   end

   // A row never written since the last clear reads as zero
   assign rd_row = rd_vld_ff ? rd_data_ff : '0;

   // Scan one nibble, top cell first
   assign nib = shift_ff[CELLS-1 -: NIB_W];

   always_comb begin
      nib_pop  = '0;
      nib_run  = run_ff;
      nib_best = best_ff;
      for (int i = NIB_W - 1; i >= 0; i--) begin
         nib_pop = nib_pop + CNT_W'(nib[i]);
         if (!nib[i]) begin
            nib_run = nib_run + CNT_W'(1);
         end else begin
            if (nib_run > nib_best) begin
               nib_best = nib_run;
            end
            nib_run = '0;
         end
      end
   end

   always_comb begin
      shift_in = shift_ff;
      pop_in   = pop_ff;
      run_in   = run_ff;
      best_in  = best_ff;
      if (cmd.accept) begin
         pop_in  = '0;
         run_in  = '0;
         best_in = '0;
      end else if (cmd.scan_load) begin
         shift_in = rd_row;
      end else if (cmd.scan_nib) begin
         shift_in = shift_ff << NIB_W;
         pop_in   = pop_ff + nib_pop;
         run_in   = nib_run;
         best_in  = nib_best;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
      pop_ff   <= pop_in;
      run_ff   <= run_in;
      best_ff  <= best_in;
   end

   // Result register: load on finish, drop when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_row_ff  <= cur_row_ff;
         rsp_pop_ff  <= pop_ff;
         rsp_run_ff  <= check_ff ? best_ff : '0;
         rsp_trig_ff <= fire;
      end
   end

   assign status.rsp_free = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid      = rsp_valid_ff;
   assign row_out         = ROW_FIELD_W'(rsp_row_ff);
   assign population      = CNT_FIELD_W'(rsp_pop_ff);
   assign max_zero_run    = CNT_FIELD_W'(rsp_run_ff);
   assign trigger         = rsp_trig_ff;

endmodule

`default_nettype wire

/* rtl/ca_row_ctrl.sv */
// Controller of the row engine: accepts items and sequences the row scan.
// Depends on ca_row_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none

`include "cellular_automaton_row_engine_top_assert.svh"

module ca_row_ctrl (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_tvalid,
   output logic                             req_tready,
   input  wire logic                        req_kind,
   output ca_row_pkg::ca_row_cmd_type       cmd,
   input  wire ca_row_pkg::ca_row_status_type status
);
   import ca_row_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN_RD,
      S_SCAN_LD,
      S_SCAN_NIB,
      S_FINISH
   } state_type;

   state_type         state_ff, state_in;
   logic [ROW_AW-1:0] row_ff, row_in;
   logic [NIB_CW-1:0] nib_ff, nib_in;
   logic              nib_last;
   logic              row_last;

   assign nib_last = nib_ff == NIB_CW'(NIB_N - 1);
   assign row_last = row_ff == '0;

   // Next state and scan counters
   always_comb begin
      state_in = state_ff;
      row_in   = row_ff;
      nib_in   = nib_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               row_in   = ROW_AW'(ROWS - 1);
               state_in = S_SCAN_RD;
            end
         end
         S_SCAN_RD: begin
            state_in = S_SCAN_LD;
         end
         S_SCAN_LD: begin
            nib_in   = '0;
            state_in = S_SCAN_NIB;
         end
         S_SCAN_NIB: begin
            nib_in = nib_ff + NIB_CW'(1);
            if (nib_last) begin
               if (row_last) begin
                  state_in = S_FINISH;
               end else begin
                  row_in   = row_ff - ROW_AW'(1);
                  state_in = S_SCAN_RD;
               end
            end
         end
         S_FINISH: begin
            if (status.rsp_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         row_ff   <= '0;
         nib_ff   <= '0;
      end else begin
         state_ff <= state_in;
         row_ff   <= row_in;
         nib_ff   <= nib_in;
      end
   end

   // Commands to the datapath
   assign req_tready    = state_ff == S_IDLE;
   assign cmd.accept    = (state_ff == S_IDLE) && req_tvalid;
   assign cmd.seed      = req_kind == REQ_SEED;
   assign cmd.rd_scan   = state_ff == S_SCAN_RD;
   assign cmd.scan_addr = row_ff;
   assign cmd.scan_load = state_ff == S_SCAN_LD;
   assign cmd.scan_nib  = state_ff == S_SCAN_NIB;
   assign cmd.finish    = (state_ff == S_FINISH) && status.rsp_free;

   `CAR_ASSERT_NEXT(a_accept_starts_scan, cmd.accept,
      state_ff == S_SCAN_RD && row_ff == ROW_AW'(ROWS - 1))
   `CAR_ASSERT_NEXT(a_last_nibble_ends,
      state_ff == S_SCAN_NIB && nib_last && row_last, state_ff == S_FINISH)
   `CAR_ASSERT_NEXT(a_finish_returns_idle, cmd.finish, state_ff == S_IDLE)
   `CAR_ASSERT_ALWAYS(a_finish_waits_free, !(state_ff == S_FINISH && !status.rsp_free) || !cmd.finish)

endmodule

`default_nettype wire

/* rtl/cellular_automaton_row_engine_top.sv */
// Top level of the elementary cellular automaton row engine.
// Depends on ca_row_pkg, ca_row_ctrl and ca_row_dpath.
//
//   channel | direction | tdata / data                          | tuser / index
//   req     | in        | seed_row, left_in, right_in           | req_type
//   rsp     | out       | row_out, population, max_zero_run     | trigger
//   csr     | in        | register write data                   | register index
//
// Every item is accepted, scanned and finished: the population and zero-run scan
// fetches each stored row through the row store's single read port (read, then
// load) and then walks it four cells per cycle.
// Reset is synchronous and clears the row store (valid bits), counters and
// registers. A finished result waits in the output register while the next
// item is accepted; that item stalls only at its finish step if rsp is still full.
// csr writes are always taken.
`timescale 1ns / 1ps
`default_nettype none

module cellular_automaton_row_engine_top (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_tvalid,
   output logic                                       req_tready,
   // seed_row [31:0], left_in [32], right_in [33], zero pad
   input  wire logic [ca_row_pkg::REQ_TDATA_W-1:0]    req_tdata,
   // req_type [0]
   input  wire logic                                  req_tuser,
   output logic                                       rsp_tvalid,
   input  wire logic                                  rsp_tready,
   // row_out [31:0], population [40:32], max_zero_run [49:41], zero pad
   output logic [ca_row_pkg::RSP_TDATA_W-1:0]         rsp_tdata,
   // trigger [0]
   output logic                                       rsp_tuser,
   input  wire logic                                  csr_valid,
   output logic                                       csr_ready,
   input  wire logic [ca_row_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [ca_row_pkg::CSR_DATA_W-1:0]     csr_data
);
   import ca_row_pkg::*;

   ca_row_cmd_type           cmd;
   ca_row_status_type        status;
   logic [ROW_FIELD_W-1:0]   seed_row;
   logic                     left_in;
   logic                     right_in;
   logic [ROW_FIELD_W-1:0]   row_out;
   logic [CNT_FIELD_W-1:0]   population;
   logic [CNT_FIELD_W-1:0]   max_zero_run;

   // Unpack request fields
   assign seed_row = req_tdata[ROW_FIELD_W-1:0];
   assign left_in  = req_tdata[ROW_FIELD_W];
   assign right_in = req_tdata[ROW_FIELD_W+1];

   // Config writes never stall
   assign csr_ready = 1'b1;

   ca_row_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_kind   (req_tuser),
      .cmd        (cmd),
      .status     (status)
   );

   ca_row_dpath u_dpath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .seed_row     (seed_row),
      .left_in      (left_in),
      .right_in     (right_in),
      .csr_write    (csr_valid && csr_ready),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .row_out      (row_out),
      .population   (population),
      .max_zero_run (max_zero_run),
      .trigger      (rsp_tuser)
   );

   // Pack result fields, lowest field first
   assign rsp_tdata = {{RSP_PAD_W{1'b0}}, max_zero_run, population, row_out};

endmodule

`default_nettype wire

/* tb/sv/cellular_automaton_row_engine_top_test.sv */
// Self-checking bench for the cellular automaton row engine: predicts every report
// from its own row history and compares it on the rsp stream. Needs ca_row_pkg
// and cellular_automaton_row_engine_top.
`timescale 1ns / 1ps

module cellular_automaton_row_engine_top_test;
   import ca_row_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED = 2'd3;
   localparam int PHASES = 8;
   localparam int PHASE_ITEMS = 80;

   // One report as the engine returns it
   typedef struct packed {
      logic [ROW_FIELD_W-1:0] row;
      logic [CNT_FIELD_W-1:0] population;
      logic [CNT_FIELD_W-1:0] zero_run;
      logic                   trigger;
   } generation_report_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic req_tuser = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic rsp_tuser;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   // Predicted engine state and registers
   logic [CELLS-1:0] history [ROWS];
   logic [ROW_AW-1:0] newest_slot;
   logic [GEN_W-1:0] generation;
   logic [GEN_W-1:0] last_fire_gen;
   logic [RULE_W-1:0] rule_table;
   logic [THR_W-1:0] run_limit;
   logic [GEN_W-1:0] holdoff;

   generation_report_type pending_reports [$];
   int mismatches = 0;
   int requests_sent = 0;
   int seeds_sent = 0;
   int reports_checked = 0;
   int triggers_seen = 0;
   int register_writes = 0;
   int rsp_stall_left = 0;
   bit pace_req = 1'b1;
   bit pace_rsp = 1'b1;

   cellular_automaton_row_engine_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Apply one request to the predicted state and return the report it causes
   function automatic generation_report_type predict_generation(input logic kind,
         input logic [ROW_FIELD_W-1:0] seed, input logic left_edge, input logic right_edge);
      generation_report_type rep;
      logic [CELLS+1:0] padded;
      logic [CELLS-1:0] grown;
      logic [GEN_W-1:0] since_fire;
      int unsigned run, best, live;
      int r, b;
      rep = '0;
      if (kind == REQ_SEED) begin
         for (r = 0; r < ROWS; r++) history[r] = '0;
         history[0] = seed[CELLS-1:0];
         newest_slot = '0;
         generation = '0;
         last_fire_gen = '0;
      end else begin
         // Each cell looks up {left, self, right} in the rule table
         padded = {left_edge, history[newest_slot], right_edge};
         for (b = 0; b < CELLS; b++) grown[b] = rule_table[padded[b +: 3]];
         newest_slot = ROW_AW'((newest_slot + 1) % ROWS);
         history[newest_slot] = grown;
         generation = generation + 1'b1;
         since_fire = generation - last_fire_gen;
         if (since_fire > holdoff) begin
            // Scan top slot down, high cell down; an open run at the end is dropped
            run = 0;
            best = 0;
            for (r = ROWS - 1; r >= 0; r--) begin
               for (b = CELLS - 1; b >= 0; b--) begin
                  if (history[r][b] == 1'b0) begin
                     run++;
                  end else begin
                     if (run > best) best = run;
                     run = 0;
                  end
               end
            end
            rep.zero_run = best[CNT_FIELD_W-1:0];
            if (best > run_limit) begin
               rep.trigger = 1'b1;
               last_fire_gen = generation;
            end
         end
      end
      live = 0;
      for (r = 0; r < ROWS; r++) live += $countones(history[r]);
      rep.population = live[CNT_FIELD_W-1:0];
      rep.row = history[newest_slot];
      return rep;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
         input logic [31:0] want);
      mismatches++;
      $display("%0t mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
   endtask

   // Send one item, pausing first at random, and predict its report on acceptance
   task automatic send_item(input logic kind, input logic [ROW_FIELD_W-1:0] seed,
         input logic left_edge, input logic right_edge);
      if (pace_req && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= {{(REQ_TDATA_W - REQ_USED_W){1'b0}}, right_edge, left_edge, seed};
      do @(posedge clock); while (!req_tready);
      pending_reports.push_back(predict_generation(kind, seed, left_edge, right_edge));
      requests_sent++;
      if (kind == REQ_SEED) seeds_sent++;
   endtask

   // Drop valid and hold until every report is back and the engine is quiet
   task automatic drain_engine();
      req_tvalid <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
         input logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      register_writes++;
      case (idx)
         CSR_RULE:      rule_table = value[RULE_W-1:0];
         CSR_THRESHOLD: run_limit = value[THR_W-1:0];
         CSR_HOLDOFF:   holdoff = value[GEN_W-1:0];
         default: ;
      endcase
   endtask

   // Write all registers while idle; upper data bits are noise the engine drops
   task automatic program_engine(input logic [RULE_W-1:0] rule, input logic [THR_W-1:0] limit,
         input logic [GEN_W-1:0] gens);
      drain_engine();
      write_register(CSR_UNMAPPED, CSR_DATA_W'($urandom));
      write_register(CSR_RULE, {8'($urandom), rule});
      write_register(CSR_THRESHOLD, {7'($urandom), limit});
      write_register(CSR_HOLDOFF, gens);
      csr_valid <= 1'b0;
   endtask

   // Defaults straight after reset: evolve the empty store, then a single live cell
   task automatic test_power_up_defaults();
      send_item(REQ_STEP, 32'h0, 1'b0, 1'b0);
      send_item(REQ_STEP, 32'h0, 1'b1, 1'b1);
      send_item(REQ_SEED, 32'h0001_0000, 1'b0, 1'b0);
      repeat (10) send_item(REQ_STEP, 32'h0, 1'b0, 1'b0);
   endtask

   // Edge cells fed from both neighbours in every combination
   task automatic test_edge_cells();
      program_engine(8'd150, 9'd0, 16'd0);
      send_item(REQ_SEED, 32'hFFFF_FFFF, 1'b0, 1'b0);
      send_item(REQ_STEP, 32'h0, 1'b0, 1'b0);
      send_item(REQ_STEP, 32'h0, 1'b1, 1'b1);
      send_item(REQ_STEP, 32'h0, 1'b0, 1'b1);
      send_item(REQ_STEP, 32'h0, 1'b1, 1'b0);
      send_item(REQ_SEED, 32'h8000_0001, 1'b1, 1'b1);
      send_item(REQ_STEP, 32'hFFFF_FFFF, 1'b1, 1'b0);
   endtask

   // Register extremes: never checked, then checked on every generation
   task automatic test_register_extremes();
      program_engine(8'hFF, 9'd256, 16'hFFFF);
      send_item(REQ_SEED, 32'h0, 1'b1, 1'b0);
      send_item(REQ_STEP, 32'h0, 1'b0, 1'b0);
      send_item(REQ_STEP, 32'h0, 1'b0, 1'b1);
      program_engine(8'h00, 9'd0, 16'd0);
      send_item(REQ_SEED, 32'hA5A5_A5A5, 1'b0, 1'b1);
      send_item(REQ_STEP, 32'h0, 1'b1, 1'b1);
   endtask

   // Phases of seeded runs with random content, each under its own settings
   task automatic test_random_runs();
      logic [ROW_FIELD_W-1:0] seed;
      logic kind;
      int phase, n, k;
      for (phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: program_engine(8'd30, 9'd0, 16'd0);
            1: program_engine(8'd0, 9'd256, 16'hFFFF);
            2: program_engine(8'hFF, 9'($urandom_range(0, 256)), 16'($urandom));
            3: program_engine(8'd110, 9'($urandom_range(5, 20)), 16'($urandom_range(0, 12)));
            PHASES - 1: program_engine(8'd90, 9'd3, 16'd2);
            default: program_engine(8'($urandom),
               ($urandom_range(0, 4) == 0) ? 9'd256 : 9'($urandom_range(0, 40)),
               16'($urandom_range(0, 16)));
         endcase
         // One phase without pauses mid-run, and none at all at the end
         pace_req = (phase != 2) && (phase != PHASES - 1);
         pace_rsp = pace_req;
         for (n = 0; n < PHASE_ITEMS; n++) begin
            kind = (n == 0 || $urandom_range(0, 11) == 0) ? REQ_SEED : REQ_STEP;
            k = $urandom_range(0, CELLS - 1);
            case ($urandom_range(0, 5))
               0: seed = 32'h1 << k;
               1: seed = $urandom & $urandom & $urandom;
               2: seed = ~(32'h1 << k);
               3: seed = ($urandom_range(0, 1) == 0) ? 32'h0 : 32'hFFFF_FFFF;
               default: seed = $urandom;
            endcase
            send_item(kind, seed, 1'($urandom), 1'($urandom));
         end
      end
   endtask

   // Hold rsp_tready low in bursts while pacing is on
   always @(posedge clock) begin
      if (rsp_stall_left != 0) begin
         rsp_stall_left <= rsp_stall_left - 1;
      end else if (pace_rsp && $urandom_range(0, 5) == 0) begin
         rsp_tready <= 1'b0;
         rsp_stall_left <= $urandom_range(0, 17);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Compare each report with the oldest prediction
   always @(posedge clock) begin
      generation_report_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_reports.size() == 0) begin
            report_mismatch("report with nothing pending", rsp_tdata[31:0], 32'h0);
         end else begin
            want = pending_reports.pop_front();
            reports_checked++;
            if (rsp_tuser) triggers_seen++;
            if (rsp_tdata[ROW_FIELD_W-1:0] !== want.row)
               report_mismatch("row_out", rsp_tdata[ROW_FIELD_W-1:0], want.row);
            if (rsp_tdata[ROW_FIELD_W +: CNT_FIELD_W] !== want.population)
               report_mismatch("population", 32'(rsp_tdata[ROW_FIELD_W +: CNT_FIELD_W]),
                  32'(want.population));
            if (rsp_tdata[ROW_FIELD_W + CNT_FIELD_W +: CNT_FIELD_W] !== want.zero_run)
               report_mismatch("max_zero_run",
                  32'(rsp_tdata[ROW_FIELD_W + CNT_FIELD_W +: CNT_FIELD_W]),
                  32'(want.zero_run));
            if (rsp_tuser !== want.trigger)
               report_mismatch("trigger", 32'(rsp_tuser), 32'(want.trigger));
         end
      end
   end

   initial begin
      int r;
      for (r = 0; r < ROWS; r++) history[r] = '0;
      newest_slot = '0;
      generation = '0;
      last_fire_gen = '0;
      rule_table = RULE_RESET;
      run_limit = THRESHOLD_RESET;
      holdoff = HOLDOFF_RESET;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_power_up_defaults();
      test_edge_cells();
      test_register_extremes();
      test_random_runs();
      // Drain, then give the engine one more item time for stray reports
      drain_engine();
      repeat (100) @(posedge clock);
      $display("ran %0d requests (%0d seeds) over %0d register writes",
         requests_sent, seeds_sent, register_writes);
      $display("checked %0d reports, %0d with the trigger raised, %0d mismatches",
         reports_checked, triggers_seen, mismatches);
      if (mismatches == 0) begin
         $display("cellular_automaton_row_engine_top_test: PASS");
      end else begin
         $display("cellular_automaton_row_engine_top_test: FAIL");
      end
      $finish;
   end

   // Stop a hung run
   initial begin
      #5_000_000;
      $display("timeout with %0d reports pending", pending_reports.size());
      $display("cellular_automaton_row_engine_top_test: FAIL");
      $finish;
   end

endmodule
